// File: rtl/ofnj_pkg.sv
// ----------------------------------------------------------------------------
// ofnj_pkg
// Shared widths, request codes and configuration register indexes of the
// outlier-filtered neighbour-joining tree builder.
// ----------------------------------------------------------------------------
package ofnj_pkg;

  localparam int MAX_LEAVES = 32;
  localparam int NODE_SPAN  = 2 * MAX_LEAVES;
  localparam int LEAF_W     = $clog2(MAX_LEAVES);
  localparam int CNT_W      = $clog2(MAX_LEAVES + 1);
  localparam int NODE_W     = $clog2(NODE_SPAN);
  localparam int DADDR_W    = 2 * NODE_W;
  localparam int DIST_DEPTH = NODE_SPAN * NODE_SPAN;

  localparam int REQ_W   = 2;
  localparam int IDX_W   = 5;
  localparam int VAL_W   = 16;
  localparam int LEN_W   = 16;
  localparam int RATIO_W = 16;
  localparam int DIST_W  = 24;
  localparam int ID_W    = 6;

  localparam int RS_W    = DIST_W + CNT_W - 1;
  localparam int Q_W     = RS_W + 3;
  localparam int BR_W    = RS_W + 3;
  localparam int DIV_W   = RS_W + 1;
  localparam int DVS_W   = CNT_W + 1;
  localparam int DCNT_W  = $clog2(DIV_W + 1);
  localparam int PROD_W  = LEN_W + 1 + RATIO_W;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam int LC_W      = 6;

  localparam logic [REQ_W-1:0] REQ_LOAD_LEN  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_DIST = 2'd1;
  localparam logic [REQ_W-1:0] REQ_START     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEAF_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_RATIO = 1'b1;

endpackage

// File: rtl/ofnj_in_if.sv
// ----------------------------------------------------------------------------
// ofnj_in_if
// Request channel: load requests and the start request.
// ----------------------------------------------------------------------------
interface ofnj_in_if;
  logic                            valid;
  logic                            ready;
  logic [ofnj_pkg::REQ_W-1:0]      req_type;
  logic [ofnj_pkg::IDX_W-1:0]      row_index;
  logic [ofnj_pkg::IDX_W-1:0]      col_index;
  logic [ofnj_pkg::VAL_W-1:0]      value_in;

  modport source (output valid, req_type, row_index, col_index, value_in, input ready);
  modport sink   (input valid, req_type, row_index, col_index, value_in, output ready);
endinterface

// File: rtl/ofnj_out_if.sv
// ----------------------------------------------------------------------------
// ofnj_out_if
// Result channel: one request per join, then a final root and status request.
// ----------------------------------------------------------------------------
interface ofnj_out_if;
  logic                              valid;
  logic                              ready;
  logic [ofnj_pkg::ID_W-1:0]         node_id;
  logic [ofnj_pkg::ID_W-1:0]         left_child;
  logic [ofnj_pkg::ID_W-1:0]         right_child;
  logic signed [ofnj_pkg::DIST_W-1:0] left_branch;
  logic signed [ofnj_pkg::DIST_W-1:0] right_branch;
  logic [ofnj_pkg::ID_W-1:0]         root_id;
  logic                              status;
  logic                              is_final;

  modport source (output valid, node_id, left_child, right_child, left_branch,
                  right_branch, root_id, status, is_final, input ready);
  modport sink   (input valid, node_id, left_child, right_child, left_branch,
                  right_branch, root_id, status, is_final, output ready);
endinterface

// File: rtl/outlier_filtered_neighbor_joining.sv
// ----------------------------------------------------------------------------
// outlier_filtered_neighbor_joining
// Loads read lengths and a distance matrix, removes outlier reads and builds
// a neighbour-joining tree, reporting each join and then the root.
// ----------------------------------------------------------------------------
// Load requests are accepted back to back while the block is idle.
// A start request first screens the L reads for outliers, then joins the n
// active nodes one pair at a time; the pace of both is set by the single
// read port of the distance memory, plus any result stalls.
// Reset is synchronous: it clears the sequencer, the control registers and the
// output valid; the length and distance memories hold nothing until loaded.
module outlier_filtered_neighbor_joining (
  input  logic                              clk,
  input  logic                              rst_n,
  ofnj_in_if.sink                           in_if,
  ofnj_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [ofnj_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ofnj_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int ST_W = 6;
  localparam logic [ST_W-1:0] ST_IDLE   = 6'd0;
  localparam logic [ST_W-1:0] ST_O_ROW  = 6'd1;
  localparam logic [ST_W-1:0] ST_O_LEN  = 6'd2;
  localparam logic [ST_W-1:0] ST_O_J    = 6'd3;
  localparam logic [ST_W-1:0] ST_O_MUL  = 6'd4;
  localparam logic [ST_W-1:0] ST_O_CMP  = 6'd5;
  localparam logic [ST_W-1:0] ST_LOOP   = 6'd6;
  localparam logic [ST_W-1:0] ST_R_ROW  = 6'd7;
  localparam logic [ST_W-1:0] ST_R_RD   = 6'd8;
  localparam logic [ST_W-1:0] ST_R_ACC  = 6'd9;
  localparam logic [ST_W-1:0] ST_Q_ROW  = 6'd10;
  localparam logic [ST_W-1:0] ST_Q_RD   = 6'd11;
  localparam logic [ST_W-1:0] ST_Q_MUL  = 6'd12;
  localparam logic [ST_W-1:0] ST_Q_CMP  = 6'd13;
  localparam logic [ST_W-1:0] ST_J_A    = 6'd14;
  localparam logic [ST_W-1:0] ST_J_B    = 6'd15;
  localparam logic [ST_W-1:0] ST_J_C    = 6'd16;
  localparam logic [ST_W-1:0] ST_J_X    = 6'd17;
  localparam logic [ST_W-1:0] ST_J_RB   = 6'd18;
  localparam logic [ST_W-1:0] ST_J_V    = 6'd19;
  localparam logic [ST_W-1:0] ST_J_W1   = 6'd20;
  localparam logic [ST_W-1:0] ST_J_W2   = 6'd21;
  localparam logic [ST_W-1:0] ST_DV0    = 6'd22;
  localparam logic [ST_W-1:0] ST_DV     = 6'd23;
  localparam logic [ST_W-1:0] ST_DV_FIN = 6'd24;
  localparam logic [ST_W-1:0] ST_W_1    = 6'd25;
  localparam logic [ST_W-1:0] ST_W_2    = 6'd26;
  localparam logic [ST_W-1:0] ST_W_3    = 6'd27;
  localparam logic [ST_W-1:0] ST_W_4    = 6'd28;
  localparam logic [ST_W-1:0] ST_W_5    = 6'd29;
  localparam logic [ST_W-1:0] ST_EMIT_J = 6'd30;
  localparam logic [ST_W-1:0] ST_C_UP   = 6'd31;
  localparam logic [ST_W-1:0] ST_C_DN   = 6'd32;
  localparam logic [ST_W-1:0] ST_EMIT_F = 6'd33;

  localparam int CW = ofnj_pkg::CNT_W;
  localparam int NW = ofnj_pkg::NODE_W;
  localparam int DW = ofnj_pkg::DIST_W;

  logic [ST_W-1:0]                   state_r, state_nxt;
  logic [ofnj_pkg::LC_W-1:0]         lc_r;
  logic [ofnj_pkg::RATIO_W-1:0]      ratio_r;
  logic [CW-1:0]                     cnt_r, i_r, j_r, ac_r, bi_r, bj_r;
  logic [NW-1:0]                     nn_r, a_r, x_r, ni_r, nj_r;
  logic                              kept_r, first_r;
  logic [ofnj_pkg::LEN_W-1:0]        leni_r;
  logic [ofnj_pkg::PROD_W-1:0]       prod_r;
  logic signed [DW-1:0]              dval_r, dij_r, va_r, v_r;
  logic signed [ofnj_pkg::RS_W-1:0]  acc_r, rsi_r, rsj_r;
  logic signed [ofnj_pkg::RS_W-1:0]  rs_r [ofnj_pkg::MAX_LEAVES];
  logic [NW-1:0]                     al_r [ofnj_pkg::MAX_LEAVES];
  logic signed [ofnj_pkg::Q_W-1:0]   qp_r, best_r;
  logic [ofnj_pkg::DIV_W-1:0]        dmag_r;
  logic [ofnj_pkg::DVS_W-1:0]        drem_r, dvs_r;
  logic                              dneg_r;
  logic [ofnj_pkg::DCNT_W-1:0]       dcnt_r;
  logic signed [ofnj_pkg::BR_W-1:0]  dl_r, dr_r;

  logic                              out_valid_r;
  logic [ofnj_pkg::ID_W-1:0]         o_node_r, o_left_r, o_right_r, o_root_r;
  logic signed [DW-1:0]              o_lb_r, o_rb_r;
  logic                              o_status_r, o_final_r;

  // Memory ports.
  logic                              d_we;
  logic [ofnj_pkg::DADDR_W-1:0]      d_waddr, d_raddr;
  logic [DW-1:0]                     d_wdata, d_rdata;
  logic                              l_we;
  logic [ofnj_pkg::LEAF_W-1:0]       l_waddr, l_raddr;
  logic [ofnj_pkg::LEN_W-1:0]        l_rdata;

  logic                              in_fire, out_load, out_free;
  logic [CW-1:0]                     al_ra, rs_ra;
  logic [NW-1:0]                     al_rd;
  logic signed [ofnj_pkg::RS_W-1:0]  rs_rd;
  logic                              al_we;
  logic [CW-1:0]                     al_wa;
  logic [NW-1:0]                     al_wd;
  logic signed [DW-1:0]              d_rs;

  logic [ofnj_pkg::LEN_W:0]          len_sum;
  logic [ofnj_pkg::PROD_W:0]         thr_full;
  logic [ofnj_pkg::PROD_W-16:0]      thr;
  logic                              below_thr;
  logic [CW-1:0]                     nm2;
  logic signed [CW+DW:0]             qmul;
  logic signed [ofnj_pkg::Q_W-1:0]   q_val;
  logic signed [DW+1:0]              vsum, vadj;
  logic signed [DW:0]                hsum;
  logic signed [DW-1:0]              dij_half;
  logic signed [ofnj_pkg::DIV_W-1:0] rs_diff;
  logic [ofnj_pkg::DVS_W:0]          dtrial;
  logic                              dge;
  logic signed [ofnj_pkg::BR_W-1:0]  quo_s, dl_nxt;
  logic [CW-1:0]                     lc_eff;

  assign d_rs     = $signed(d_rdata);
  assign in_fire  = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_if.ready;
  assign out_load = ((state_r == ST_EMIT_J) || (state_r == ST_EMIT_F)) && out_free;

  assign lc_eff = (lc_r > ofnj_pkg::LC_W'(ofnj_pkg::MAX_LEAVES)) ?
                  CW'(ofnj_pkg::MAX_LEAVES) : CW'(lc_r);

  ofnj_ram #(.WIDTH(DW), .DEPTH(ofnj_pkg::DIST_DEPTH)) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  ofnj_ram #(.WIDTH(ofnj_pkg::LEN_W), .DEPTH(ofnj_pkg::MAX_LEAVES)) u_len_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (in_if.value_in),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  assign l_we    = in_fire && (in_if.req_type == ofnj_pkg::REQ_LOAD_LEN);
  assign l_waddr = ofnj_pkg::LEAF_W'(in_if.row_index);
  assign l_raddr = (state_r == ST_O_ROW) ? i_r[ofnj_pkg::LEAF_W-1:0]
                                         : j_r[ofnj_pkg::LEAF_W-1:0];

  always_comb begin
    unique case (state_r)
      ST_R_ROW, ST_Q_ROW, ST_J_X, ST_C_UP: al_ra = i_r;
      ST_R_RD, ST_Q_RD:                    al_ra = j_r;
      ST_J_A:                              al_ra = bi_r;
      ST_J_B:                              al_ra = bj_r;
      ST_C_DN:                             al_ra = i_r - CW'(1);
      default:                             al_ra = '0;
    endcase
    unique case (state_r)
      ST_Q_RD: rs_ra = j_r;
      ST_J_A:  rs_ra = bi_r;
      ST_J_B:  rs_ra = bj_r;
      default: rs_ra = i_r;
    endcase
  end

  assign al_rd = al_r[al_ra[ofnj_pkg::LEAF_W-1:0]];
  assign rs_rd = rs_r[rs_ra[ofnj_pkg::LEAF_W-1:0]];

  // Distance memory addressing.
  always_comb begin
    unique case (state_r)
      ST_O_J:                            d_raddr = {NW'(i_r), NW'(j_r)};
      ST_R_RD, ST_Q_RD:                  d_raddr = {a_r, al_rd};
      ST_J_B, ST_J_X:                    d_raddr = {ni_r, al_rd};
      ST_J_RB:                           d_raddr = {nj_r, x_r};
      default:                           d_raddr = '0;
    endcase
    d_we    = 1'b0;
    d_waddr = '0;
    d_wdata = '0;
    unique case (state_r)
      ST_IDLE: begin
        d_we    = in_fire && (in_if.req_type == ofnj_pkg::REQ_LOAD_DIST);
        d_waddr = {NW'(in_if.row_index), NW'(in_if.col_index)};
        d_wdata = DW'(in_if.value_in);
      end
      ST_J_W1: begin
        d_we = 1'b1; d_waddr = {nn_r, x_r}; d_wdata = v_r;
      end
      ST_J_W2: begin
        d_we = 1'b1; d_waddr = {x_r, nn_r}; d_wdata = v_r;
      end
      ST_W_1: begin
        d_we = 1'b1; d_waddr = {nn_r, ni_r}; d_wdata = dl_r[DW-1:0];
      end
      ST_W_2: begin
        d_we = 1'b1; d_waddr = {ni_r, nn_r}; d_wdata = dl_r[DW-1:0];
      end
      ST_W_3: begin
        d_we = 1'b1; d_waddr = {nn_r, nj_r}; d_wdata = dr_r[DW-1:0];
      end
      ST_W_4: begin
        d_we = 1'b1; d_waddr = {nj_r, nn_r}; d_wdata = dr_r[DW-1:0];
      end
      ST_W_5: begin
        d_we = 1'b1; d_waddr = {nn_r, nn_r}; d_wdata = '0;
      end
      default: begin
        d_we = 1'b0;
      end
    endcase
  end

  // Datapath arithmetic.
  assign len_sum   = {1'b0, leni_r} + {1'b0, l_rdata};
  assign thr_full  = {1'b0, prod_r} + (ofnj_pkg::PROD_W + 1)'(16'hFFFF);
  assign thr       = thr_full[ofnj_pkg::PROD_W:16];
  assign below_thr = $signed({dval_r[DW-1], dval_r}) <
                     $signed({{(DW - ofnj_pkg::PROD_W + 16){1'b0}}, thr});
  assign nm2       = ac_r - CW'(2);
  assign qmul      = $signed({1'b0, nm2}) * d_rs;
  assign q_val     = qp_r - ofnj_pkg::Q_W'(rsi_r) - ofnj_pkg::Q_W'(rsj_r);
  assign vsum      = (DW+2)'(va_r) + (DW+2)'(d_rs) - (DW+2)'(dij_r);
  assign vadj      = vsum + (DW+2)'({1'b0, vsum[DW+1]});
  assign hsum      = (DW+1)'(dij_r) + (DW+1)'({1'b0, dij_r[DW-1]});
  assign dij_half  = hsum[DW:1];
  assign rs_diff   = ofnj_pkg::DIV_W'(rsi_r) - ofnj_pkg::DIV_W'(rsj_r);
  assign dtrial    = {drem_r, dmag_r[ofnj_pkg::DIV_W-1]};
  assign dge       = dtrial >= {1'b0, dvs_r};
  assign quo_s     = dneg_r ? -ofnj_pkg::BR_W'({1'b0, dmag_r})
                            : ofnj_pkg::BR_W'({1'b0, dmag_r});
  assign dl_nxt    = ofnj_pkg::BR_W'(dij_half) + quo_s;

  // Active list write port.
  always_comb begin
    al_we = 1'b0;
    al_wa = '0;
    al_wd = '0;
    unique case (state_r)
      ST_O_J: begin
        al_we = ((j_r == cnt_r) || kept_r) && kept_r;
        al_wa = ac_r;
        al_wd = NW'(i_r);
      end
      ST_C_UP: begin
        al_we = (i_r < ac_r);
        al_wa = i_r - CW'(1);
        al_wd = al_rd;
      end
      ST_C_DN: begin
        al_we = 1'b1;
        al_wa = i_r;
        al_wd = (i_r == '0) ? nn_r : al_rd;
      end
      default: begin
        al_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire && (in_if.req_type == ofnj_pkg::REQ_START)) begin
                   state_nxt = ST_O_ROW;
                 end
      ST_O_ROW:  state_nxt = (i_r == cnt_r) ? ST_LOOP : ST_O_LEN;
      ST_O_LEN:  state_nxt = ST_O_J;
      ST_O_J: begin
        if ((j_r == cnt_r) || kept_r) begin
          state_nxt = ST_O_ROW;
        end else if (j_r != i_r) begin
          state_nxt = ST_O_MUL;
        end
      end
      ST_O_MUL:  state_nxt = ST_O_CMP;
      ST_O_CMP:  state_nxt = ST_O_J;
      ST_LOOP:   state_nxt = (ac_r <= CW'(1)) ? ST_EMIT_F : ST_R_ROW;
      ST_R_ROW:  state_nxt = (i_r == ac_r) ? ST_Q_ROW : ST_R_RD;
      ST_R_RD:   state_nxt = (j_r == ac_r) ? ST_R_ROW : ST_R_ACC;
      ST_R_ACC:  state_nxt = ST_R_RD;
      ST_Q_ROW:  state_nxt = (i_r == ac_r) ? ST_J_A : ST_Q_RD;
      ST_Q_RD:   state_nxt = (j_r >= ac_r) ? ST_Q_ROW : ST_Q_MUL;
      ST_Q_MUL:  state_nxt = ST_Q_CMP;
      ST_Q_CMP:  state_nxt = ST_Q_RD;
      ST_J_A:    state_nxt = ST_J_B;
      ST_J_B:    state_nxt = ST_J_C;
      ST_J_C:    state_nxt = ST_J_X;
      ST_J_X:    state_nxt = (i_r == ac_r) ? ST_DV0 : ST_J_RB;
      ST_J_RB:   state_nxt = ST_J_V;
      ST_J_V:    state_nxt = ST_J_W1;
      ST_J_W1:   state_nxt = ST_J_W2;
      ST_J_W2:   state_nxt = ST_J_X;
      ST_DV0:    state_nxt = (ac_r > CW'(2)) ? ST_DV : ST_W_1;
      ST_DV:     state_nxt = (dcnt_r == ofnj_pkg::DCNT_W'(1)) ? ST_DV_FIN : ST_DV;
      ST_DV_FIN: state_nxt = ST_W_1;
      ST_W_1:    state_nxt = ST_W_2;
      ST_W_2:    state_nxt = ST_W_3;
      ST_W_3:    state_nxt = ST_W_4;
      ST_W_4:    state_nxt = ST_W_5;
      ST_W_5:    state_nxt = ST_EMIT_J;
      ST_EMIT_J: if (out_free) begin
                   state_nxt = ST_C_UP;
                 end
      ST_C_UP:   if (i_r >= ac_r) begin
                   state_nxt = ST_C_DN;
                 end
      ST_C_DN:   if (i_r == '0) begin
                   state_nxt = ST_LOOP;
                 end
      ST_EMIT_F: if (out_free) begin
                   state_nxt = ST_IDLE;
                 end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lc_r        <= '0;
      ratio_r     <= '0;
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      ac_r        <= '0;
      nn_r        <= '0;
      kept_r      <= 1'b0;
      first_r     <= 1'b0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ofnj_pkg::CFG_LEAF_COUNT: lc_r    <= cfg_wdata[ofnj_pkg::LC_W-1:0];
          ofnj_pkg::CFG_DIFF_RATIO: ratio_r <= cfg_wdata[ofnj_pkg::RATIO_W-1:0];
          default:                  lc_r    <= lc_r;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= lc_eff;
          i_r   <= '0;
          ac_r  <= '0;
        end
        ST_O_ROW: begin
          nn_r <= NW'(cnt_r);
        end
        ST_O_LEN: begin
          j_r    <= '0;
          kept_r <= 1'b0;
        end
        ST_O_J: begin
          if ((j_r == cnt_r) || kept_r) begin
            if (kept_r) begin
              ac_r <= ac_r + CW'(1);
            end
            i_r <= i_r + CW'(1);
          end else if (j_r == i_r) begin
            j_r <= j_r + CW'(1);
          end
        end
        ST_O_CMP: begin
          if (below_thr) begin
            kept_r <= 1'b1;
          end
          j_r <= j_r + CW'(1);
        end
        ST_LOOP: begin
          i_r <= '0;
        end
        ST_R_ROW: begin
          if (i_r == ac_r) begin
            i_r     <= '0;
            first_r <= 1'b1;
          end
          j_r <= '0;
        end
        ST_R_RD: begin
          if (j_r == ac_r) begin
            i_r <= i_r + CW'(1);
          end
        end
        ST_R_ACC: begin
          j_r <= j_r + CW'(1);
        end
        ST_Q_ROW: begin
          j_r <= i_r + CW'(1);
        end
        ST_Q_RD: begin
          if (j_r >= ac_r) begin
            i_r <= i_r + CW'(1);
          end
        end
        ST_Q_CMP: begin
          first_r <= 1'b0;
          j_r     <= j_r + CW'(1);
        end
        ST_J_C: begin
          i_r <= '0;
        end
        ST_J_W2: begin
          i_r <= i_r + CW'(1);
        end
        ST_DV0: begin
          dcnt_r <= ofnj_pkg::DCNT_W'(ofnj_pkg::DIV_W);
        end
        ST_DV: begin
          dcnt_r <= dcnt_r - ofnj_pkg::DCNT_W'(1);
        end
        ST_EMIT_J: begin
          i_r <= bj_r + CW'(1);
        end
        ST_C_UP: begin
          if (i_r >= ac_r) begin
            i_r <= bi_r;
          end else begin
            i_r <= i_r + CW'(1);
          end
        end
        ST_C_DN: begin
          if (i_r == '0) begin
            ac_r <= ac_r - CW'(1);
            nn_r <= nn_r + NW'(1);
          end else begin
            i_r <= i_r - CW'(1);
          end
        end
        default: begin
          kept_r <= kept_r;
        end
      endcase
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    if (al_we) begin
      al_r[al_wa[ofnj_pkg::LEAF_W-1:0]] <= al_wd;
    end
    unique case (state_r)
      ST_O_LEN:  leni_r <= l_rdata;
      ST_O_MUL: begin
        prod_r <= ofnj_pkg::PROD_W'(len_sum) * ofnj_pkg::PROD_W'(ratio_r);
        dval_r <= d_rs;
      end
      ST_R_ROW: begin
        a_r   <= al_rd;
        acc_r <= '0;
      end
      ST_R_RD: begin
        if (j_r == ac_r) begin
          rs_r[i_r[ofnj_pkg::LEAF_W-1:0]] <= acc_r;
        end
      end
      ST_R_ACC:  acc_r <= acc_r + ofnj_pkg::RS_W'(d_rs);
      ST_Q_ROW: begin
        a_r   <= al_rd;
        rsi_r <= rs_rd;
      end
      ST_Q_RD:   rsj_r <= rs_rd;
      ST_Q_MUL:  qp_r  <= ofnj_pkg::Q_W'(qmul);
      ST_Q_CMP: begin
        if (first_r || (q_val < best_r)) begin
          best_r <= q_val;
          bi_r   <= i_r;
          bj_r   <= j_r;
        end
      end
      ST_J_A: begin
        ni_r  <= al_rd;
        rsi_r <= rs_rd;
      end
      ST_J_B: begin
        nj_r  <= al_rd;
        rsj_r <= rs_rd;
      end
      ST_J_C:    dij_r <= d_rs;
      ST_J_X:    x_r   <= al_rd;
      ST_J_RB:   va_r  <= d_rs;
      ST_J_V:    v_r   <= vadj[DW:1];
      ST_DV0: begin
        dneg_r <= rs_diff[ofnj_pkg::DIV_W-1];
        dmag_r <= rs_diff[ofnj_pkg::DIV_W-1] ? ofnj_pkg::DIV_W'(-rs_diff)
                                              : ofnj_pkg::DIV_W'(rs_diff);
        drem_r <= '0;
        dvs_r  <= ofnj_pkg::DVS_W'({nm2, 1'b0});
        dl_r   <= ofnj_pkg::BR_W'(dij_r);
        dr_r   <= ofnj_pkg::BR_W'(dij_r);
      end
      ST_DV: begin
        drem_r <= dge ? ofnj_pkg::DVS_W'(dtrial - {1'b0, dvs_r})
                      : dtrial[ofnj_pkg::DVS_W-1:0];
        dmag_r <= {dmag_r[ofnj_pkg::DIV_W-2:0], dge};
      end
      ST_DV_FIN: begin
        dl_r <= dl_nxt;
        dr_r <= ofnj_pkg::BR_W'(dij_r) - dl_nxt;
      end
      default: begin
        leni_r <= leni_r;
      end
    endcase
    if (out_load) begin
      if (state_r == ST_EMIT_J) begin
        o_node_r   <= nn_r;
        o_left_r   <= ni_r;
        o_right_r  <= nj_r;
        o_lb_r     <= dl_r[DW-1:0];
        o_rb_r     <= dr_r[DW-1:0];
        o_root_r   <= '0;
        o_status_r <= 1'b0;
        o_final_r  <= 1'b0;
      end else begin
        o_node_r   <= '0;
        o_left_r   <= '0;
        o_right_r  <= '0;
        o_lb_r     <= '0;
        o_rb_r     <= '0;
        o_root_r   <= (ac_r == '0) ? '0 : al_r[0];
        o_status_r <= (ac_r == '0);
        o_final_r  <= 1'b1;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.node_id      = o_node_r;
  assign out_if.left_child   = o_left_r;
  assign out_if.right_child  = o_right_r;
  assign out_if.left_branch  = o_lb_r;
  assign out_if.right_branch = o_rb_r;
  assign out_if.root_id      = o_root_r;
  assign out_if.status       = o_status_r;
  assign out_if.is_final     = o_final_r;

endmodule

// File: rtl/ofnj_ram.sv
// ----------------------------------------------------------------------------
// ofnj_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ofnj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ofnj_checker.sv
// ----------------------------------------------------------------------------
// ofnj_checker
// Port-level checks of the neighbour-joining tree builder, bound to the top.
// ----------------------------------------------------------------------------
module ofnj_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [ofnj_pkg::REQ_W-1:0]    in_req_type,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ofnj_pkg::ID_W-1:0]     out_node_id,
  input logic [ofnj_pkg::ID_W-1:0]     out_root_id,
  input logic                          out_status,
  input logic                          out_is_final
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node_id) && $stable(out_root_id)
      && $stable(out_is_final))
    else $error("stalled result changed");

  // A start request makes the block busy in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == ofnj_pkg::REQ_START) |=> !in_ready)
    else $error("block took a request straight after a start");

  // A run with no surviving read reports root zero and no node.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_final && out_status |-> (out_root_id == '0) && (out_node_id == '0))
    else $error("failed run reported a node");

  // Join requests carry no root or status.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_final |-> (out_root_id == '0) && !out_status)
    else $error("join request carried root or status");

endmodule

bind outlier_filtered_neighbor_joining ofnj_checker u_ofnj_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .in_req_type  (in_if.req_type),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_node_id  (out_if.node_id),
  .out_root_id  (out_if.root_id),
  .out_status   (out_if.status),
  .out_is_final (out_if.is_final)
);
